### design/svis_pkg.sv
// Shared types and constants for the sparse indexed vector store.
// Used by the controller, the datapath and the top level; depends on nothing.
package svis_pkg;

	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;
	localparam int SIZE_W   = 11;
	localparam int TOL_W    = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_SET      = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_RD_ELEM  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_RD_ENTRY = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_IDX_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STS_POS_RANGE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_TOL    = 1'd1;

	// list memory read address select
	localparam logic [1:0] LRD_POS  = 2'd0;
	localparam logic [1:0] LRD_LAST = 2'd1;
	localparam logic [1:0] LRD_CLR  = 2'd2;

	typedef struct packed {
		logic       capture;
		logic       init_wr;
		logic       calc;
		logic       commit;
		logic       rem_move;
		logic       rem_unlist;
		logic       clr_start;
		logic       clr_step;
		logic       clr_done;
		logic       entry_addr;
		logic [1:0] lrd_sel;
		logic       load_result;
	} cmd_t;

	typedef struct packed {
		logic                init_last;
		logic [ACTION_W-1:0] action;
		logic                idx_bad;
		logic                pos_bad;
		logic                remove_needed;
		logic                clr_more;
		logic                clr_pend;
	} sts_t;

endpackage

### design/svis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the element store, slot map and index list.
module svis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### design/svis_datapath.sv
// Datapath: element store, slot map, index list, config registers and result registers.
// Depends on svis_pkg and svis_ram; driven by svis_ctrl through cmd_t / sts_t.
module svis_datapath
	import svis_pkg::*;
#(
	parameter int CAPACITY    = 1024,
	parameter int VALUE_WIDTH = 48,
	localparam int IDX_W  = $clog2(CAPACITY),
	localparam int LEN_W  = $clog2(CAPACITY + 1),
	localparam int SLOT_W = IDX_W + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output sts_t                          sts,
	input  logic                          cfg_write_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic [ACTION_W-1:0]           action,
	input  logic [IDX_W-1:0]              index,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic [IDX_W-1:0]              list_position,
	output logic [STATUS_W-1:0]           status,
	output logic signed [VALUE_WIDTH-1:0] element_value,
	output logic [IDX_W-1:0]              entry_index,
	output logic [LEN_W-1:0]              nonzero_count
);

	localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	// captured item
	logic [ACTION_W-1:0]           action_q;
	logic [IDX_W-1:0]              index_q;
	logic signed [VALUE_WIDTH-1:0] value_q;
	logic [IDX_W-1:0]              lpos_q;

	// configuration and control state
	logic [SIZE_W-1:0] size_q;
	logic [TOL_W-1:0]  tol_q;
	logic [LEN_W-1:0]  len_q;
	logic [IDX_W-1:0]  init_q;
	logic [LEN_W-1:0]  clr_q;
	logic              clr_pend_q;

	// working registers
	logic signed [VALUE_WIDTH-1:0] sum_q;
	logic                          old_zero_q;
	logic [SLOT_W-1:0]             slot_q;
	logic signed [VALUE_WIDTH-1:0] committed_q;

	// memory ports
	logic                          elem_we;
	logic [IDX_W-1:0]              elem_wr_addr;
	logic [VALUE_WIDTH-1:0]        elem_wr_data;
	logic [IDX_W-1:0]              elem_rd_addr;
	logic [VALUE_WIDTH-1:0]        elem_rd_data;
	logic                          slot_we;
	logic [IDX_W-1:0]              slot_wr_addr;
	logic [SLOT_W-1:0]             slot_wr_data;
	logic [SLOT_W-1:0]             slot_rd_data;
	logic                          list_we;
	logic [IDX_W-1:0]              list_wr_addr;
	logic [IDX_W-1:0]              list_wr_data;
	logic [IDX_W-1:0]              list_rd_addr;
	logic [IDX_W-1:0]              list_rd_data;

	logic [LEN_W-1:0]              len_m1;
	logic [VALUE_WIDTH:0]          sum_ext;
	logic signed [VALUE_WIDTH-1:0] sat_sum;
	logic                          new_zero;
	logic                          do_append;
	logic [VALUE_WIDTH-1:0]        commit_val;

	function automatic logic within_tol(input logic [VALUE_WIDTH-1:0] x,
			input logic [TOL_W-1:0] tol);
		logic [VALUE_WIDTH:0] ext;
		logic [VALUE_WIDTH:0] mag;
		ext = {x[VALUE_WIDTH-1], x};
		mag = x[VALUE_WIDTH-1] ? (~ext + (VALUE_WIDTH+1)'(1)) : ext;
		return mag <= (VALUE_WIDTH+1)'(tol);
	endfunction

	svis_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_elem_ram (
		.clk     (clk),
		.we      (elem_we),
		.wr_addr (elem_wr_addr),
		.wr_data (elem_wr_data),
		.rd_addr (elem_rd_addr),
		.rd_data (elem_rd_data)
	);

	svis_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
		.clk     (clk),
		.we      (slot_we),
		.wr_addr (slot_wr_addr),
		.wr_data (slot_wr_data),
		.rd_addr (index_q),
		.rd_data (slot_rd_data)
	);

	svis_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_list_ram (
		.clk     (clk),
		.we      (list_we),
		.wr_addr (list_wr_addr),
		.wr_data (list_wr_data),
		.rd_addr (list_rd_addr),
		.rd_data (list_rd_data)
	);

	assign len_m1 = len_q - LEN_W'(1);

	always_comb begin
		unique case (cmd.lrd_sel)
			LRD_LAST: list_rd_addr = len_m1[IDX_W-1:0];
			LRD_CLR:  list_rd_addr = clr_q[IDX_W-1:0];
			default:  list_rd_addr = lpos_q;
		endcase
	end

	assign elem_rd_addr = cmd.entry_addr ? list_rd_data : index_q;

	// saturating add of stored element and operand
	assign sum_ext = {elem_rd_data[VALUE_WIDTH-1], elem_rd_data}
		+ {value_q[VALUE_WIDTH-1], value_q};
	always_comb begin
		if (sum_ext[VALUE_WIDTH] != sum_ext[VALUE_WIDTH-1]) begin
			sat_sum = sum_ext[VALUE_WIDTH] ? VMIN : VMAX;
		end else begin
			sat_sum = sum_ext[VALUE_WIDTH-1:0];
		end
	end

	assign new_zero   = within_tol(sum_q, tol_q);
	assign do_append  = old_zero_q && !new_zero && !slot_q[IDX_W]
		&& (len_q < LEN_W'(CAPACITY));
	// a value that drops into the tolerance band is stored as exactly zero
	assign commit_val = (!old_zero_q && new_zero) ? '0 : sum_q;

	always_comb begin
		elem_we      = 1'b0;
		elem_wr_addr = index_q;
		elem_wr_data = commit_val;
		slot_we      = 1'b0;
		slot_wr_addr = index_q;
		slot_wr_data = '0;
		list_we      = 1'b0;
		list_wr_addr = len_q[IDX_W-1:0];
		list_wr_data = index_q;
		if (cmd.init_wr) begin
			elem_we      = 1'b1;
			elem_wr_addr = init_q;
			elem_wr_data = '0;
			slot_we      = 1'b1;
			slot_wr_addr = init_q;
		end
		if (cmd.commit) begin
			elem_we = 1'b1;
			if (do_append) begin
				slot_we      = 1'b1;
				slot_wr_data = {1'b1, len_q[IDX_W-1:0]};
				list_we      = 1'b1;
			end
		end
		if (cmd.rem_move) begin
			// move the last entry into the freed slot
			slot_we      = 1'b1;
			slot_wr_addr = list_rd_data;
			slot_wr_data = {1'b1, slot_q[IDX_W-1:0]};
			list_we      = 1'b1;
			list_wr_addr = slot_q[IDX_W-1:0];
			list_wr_data = list_rd_data;
		end
		if (cmd.rem_unlist) begin
			slot_we = 1'b1;
		end
		if (cmd.clr_step && clr_pend_q) begin
			elem_we      = 1'b1;
			elem_wr_addr = list_rd_data;
			elem_wr_data = '0;
			slot_we      = 1'b1;
			slot_wr_addr = list_rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= SIZE_RESET;
			tol_q      <= '0;
			len_q      <= '0;
			init_q     <= '0;
			clr_q      <= '0;
			clr_pend_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_SIZE_IN_USE: size_q <= cfg_data[SIZE_W-1:0];
					REG_ZERO_TOL:    tol_q  <= cfg_data[TOL_W-1:0];
					default:         size_q <= size_q;
				endcase
			end
			if (cmd.init_wr) begin
				init_q <= init_q + IDX_W'(1);
			end
			if (cmd.commit && do_append) begin
				len_q <= len_q + LEN_W'(1);
			end else if (cmd.rem_move) begin
				len_q <= len_m1;
			end else if (cmd.clr_done) begin
				len_q <= '0;
			end
			if (cmd.clr_start) begin
				clr_q      <= '0;
				clr_pend_q <= 1'b0;
			end else if (cmd.clr_step) begin
				clr_pend_q <= sts.clr_more;
				if (sts.clr_more) begin
					clr_q <= clr_q + LEN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			index_q  <= index;
			value_q  <= value;
			lpos_q   <= list_position;
		end
		if (cmd.calc) begin
			sum_q      <= (action_q == ACT_ADD) ? sat_sum : value_q;
			old_zero_q <= within_tol(elem_rd_data, tol_q);
			slot_q     <= slot_rd_data;
		end
		if (cmd.commit) begin
			committed_q <= commit_val;
		end
		if (cmd.load_result) begin
			status        <= STS_OK;
			element_value <= '0;
			entry_index   <= '0;
			nonzero_count <= len_q;
			case (action_q) inside
				ACT_ADD, ACT_SET: begin
					if (sts.idx_bad) begin
						status <= STS_IDX_RANGE;
					end else begin
						element_value <= committed_q;
					end
				end
				ACT_RD_ELEM: begin
					if (sts.idx_bad) begin
						status <= STS_IDX_RANGE;
					end else begin
						element_value <= elem_rd_data;
					end
				end
				ACT_RD_ENTRY: begin
					if (sts.pos_bad) begin
						status <= STS_POS_RANGE;
					end else begin
						element_value <= elem_rd_data;
						entry_index   <= list_rd_data;
					end
				end
				default: status <= STS_OK;
			endcase
		end
	end

	assign sts.init_last     = (init_q == IDX_W'(CAPACITY - 1));
	assign sts.action        = action_q;
	// sizes above CAPACITY act as CAPACITY
	assign sts.idx_bad       = (32'(index_q) >= 32'(size_q)) || (32'(index_q) >= 32'(CAPACITY));
	assign sts.pos_bad       = (32'(lpos_q) >= 32'(len_q));
	assign sts.remove_needed = !old_zero_q && new_zero && slot_q[IDX_W] && (len_q != '0);
	assign sts.clr_more      = (clr_q < len_q);
	assign sts.clr_pend      = clr_pend_q;

endmodule

### design/svis_ctrl.sv
// Controller state machine: sequences memory reads, writes and the result hand-off.
// Depends on svis_pkg; drives svis_datapath through cmd_t and reads sts_t.
module svis_ctrl
	import svis_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_INIT    = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_CHK     = 4'd2;
	localparam logic [3:0] S_CALC    = 4'd3;
	localparam logic [3:0] S_COMMIT  = 4'd4;
	localparam logic [3:0] S_REM_RD  = 4'd5;
	localparam logic [3:0] S_REM_MV  = 4'd6;
	localparam logic [3:0] S_REM_UL  = 4'd7;
	localparam logic [3:0] S_CLR     = 4'd8;
	localparam logic [3:0] S_ERD     = 4'd9;
	localparam logic [3:0] S_FIN     = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.lrd_sel = LRD_POS;
		state_d     = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				case (sts.action) inside
					ACT_ADD, ACT_SET: state_d = sts.idx_bad ? S_FIN : S_CALC;
					ACT_CLEAR: begin
						cmd.clr_start = 1'b1;
						state_d       = S_CLR;
					end
					ACT_RD_ENTRY: state_d = sts.pos_bad ? S_FIN : S_ERD;
					default:      state_d = S_FIN;
				endcase
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = sts.remove_needed ? S_REM_RD : S_FIN;
			end
			S_REM_RD: begin
				cmd.lrd_sel = LRD_LAST;
				state_d     = S_REM_MV;
			end
			S_REM_MV: begin
				cmd.lrd_sel  = LRD_LAST;
				cmd.rem_move = 1'b1;
				state_d      = S_REM_UL;
			end
			S_REM_UL: begin
				cmd.rem_unlist = 1'b1;
				state_d        = S_FIN;
			end
			S_CLR: begin
				cmd.lrd_sel  = LRD_CLR;
				cmd.clr_step = 1'b1;
				if (!sts.clr_more && !sts.clr_pend) begin
					cmd.clr_done = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_ERD: begin
				cmd.entry_addr = 1'b1;
				state_d        = S_FIN;
			end
			S_FIN: begin
				// hold the element address on the list entry while waiting
				cmd.entry_addr = (sts.action == ACT_RD_ENTRY);
				if (!out_valid_q || out_ready) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/sparse_indexed_vector_store.sv
// Top level of the sparse indexed vector store: controller plus datapath.
// Depends on svis_pkg, svis_ctrl, svis_datapath (and svis_ram below it).
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------------
//  in      | in_valid / in_ready       | action, index, value, list_position
//  out     | out_valid / out_ready     | status, element_value, entry_index, nonzero_count
//  cfg     | cfg_write_en              | cfg_index, cfg_data
//
// Each item is captured and checked, then handled: add/set reads, calculates and commits,
// with a remove sequence (read the last entry, move it, unlist) when the element leaves
// the list; a list-entry read adds an entry read; clear steps through the list once.
// After reset a clearing pass zeroes the element and slot memories; in_ready stays low
// meanwhile. A result waiting on out_ready does not block acceptance of the next item,
// only the hand-off of that item's result.
module sparse_indexed_vector_store
	import svis_pkg::*;
#(
	parameter int CAPACITY    = 1024,
	parameter int VALUE_WIDTH = 48,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int LEN_W = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ACTION_W-1:0]           action,
	input  logic [IDX_W-1:0]              index,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic [IDX_W-1:0]              list_position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [STATUS_W-1:0]           status,
	output logic signed [VALUE_WIDTH-1:0] element_value,
	output logic [IDX_W-1:0]              entry_index,
	output logic [LEN_W-1:0]              nonzero_count
);

	cmd_t cmd;
	sts_t sts;

	svis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	svis_datapath #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.index         (index),
		.value         (value),
		.list_position (list_position),
		.status        (status),
		.element_value (element_value),
		.entry_index   (entry_index),
		.nonzero_count (nonzero_count)
	);

endmodule

### tb/svis_store_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sparse indexed vector store: mirrors the element store, the nonzero
// list and both registers, and checks each result against the oldest awaited one.
// Depends on svis_pkg; instantiated beside the block by sparse_indexed_vector_store_test.
module svis_store_checker
	import svis_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [ACTION_W-1:0]    action,
	input  logic [9:0]             index,
	input  logic signed [47:0]     value,
	input  logic [9:0]             list_position,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [STATUS_W-1:0]    status,
	input  logic signed [47:0]     element_value,
	input  logic [9:0]             entry_index,
	input  logic [10:0]            nonzero_count,
	output int                     mismatch_count,
	output int                     outstanding
);

	localparam int CAP = 1024;
	localparam int VALUE_W = 48;
	localparam int IDX_W = 10;
	localparam int LEN_W = 11;
	localparam int MAX_REPORTS = 100;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] element_value;
		logic [IDX_W-1:0]          entry_index;
		logic [LEN_W-1:0]          nonzero_count;
	} store_result_t;

	logic signed [VALUE_W-1:0] element_mirror [CAP];
	bit listed [CAP];
	int slot_of [CAP];
	int nonzero_list [CAP];
	int list_len;
	int size_reg;
	int tol_reg;
	store_result_t awaited_results [$];
	store_result_t got, want;

	function automatic bit negligible(logic signed [VALUE_W-1:0] x);
		logic [VALUE_W:0] ext, mag;
		ext = {x[VALUE_W-1], x};
		mag = x[VALUE_W-1] ? ~ext + 1'b1 : ext;
		return mag <= tol_reg;
	endfunction

	function automatic void list_add(int idx);
		if (listed[idx] || list_len >= CAP)
			return;
		listed[idx] = 1'b1;
		slot_of[idx] = list_len;
		nonzero_list[list_len] = idx;
		list_len++;
	endfunction

	// move the last entry into the vacated slot
	function automatic void list_drop(int idx);
		int last;
		if (!listed[idx] || list_len == 0)
			return;
		last = nonzero_list[list_len - 1];
		nonzero_list[slot_of[idx]] = last;
		slot_of[last] = slot_of[idx];
		list_len--;
		listed[idx] = 1'b0;
	endfunction

	function automatic void store_element(int idx, logic signed [VALUE_W-1:0] next);
		bit was_zero, now_zero;
		was_zero = negligible(element_mirror[idx]);
		now_zero = negligible(next);
		element_mirror[idx] = next;
		if (was_zero && !now_zero) begin
			list_add(idx);
		end else if (!was_zero && now_zero) begin
			element_mirror[idx] = '0;
			list_drop(idx);
		end
	endfunction

	function automatic store_result_t apply_request(logic [ACTION_W-1:0] act,
			logic [IDX_W-1:0] idx, logic signed [VALUE_W-1:0] operand, logic [IDX_W-1:0] pos);
		store_result_t r;
		int limit;
		logic [VALUE_W:0] sum;
		r = '0;
		r.status = STS_OK;
		limit = (size_reg < CAP) ? size_reg : CAP;
		case (act)
			ACT_ADD, ACT_SET, ACT_RD_ELEM: begin
				if (idx >= limit) begin
					r.status = STS_IDX_RANGE;
				end else begin
					if (act == ACT_ADD) begin
						sum = {element_mirror[idx][VALUE_W-1], element_mirror[idx]}
							+ {operand[VALUE_W-1], operand};
						// an extended sign bit that differs from the sign bit means the sum left the range
						if (sum[VALUE_W] != sum[VALUE_W-1])
							store_element(idx, sum[VALUE_W] ? VALUE_MIN : VALUE_MAX);
						else
							store_element(idx, sum[VALUE_W-1:0]);
					end else if (act == ACT_SET) begin
						store_element(idx, operand);
					end
					r.element_value = element_mirror[idx];
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < list_len; i++) begin
					element_mirror[nonzero_list[i]] = '0;
					listed[nonzero_list[i]] = 1'b0;
				end
				list_len = 0;
			end
			ACT_RD_ENTRY: begin
				if (pos >= list_len) begin
					r.status = STS_POS_RANGE;
				end else begin
					r.entry_index = IDX_W'(nonzero_list[pos]);
					r.element_value = element_mirror[nonzero_list[pos]];
				end
			end
			default: ;
		endcase
		r.nonzero_count = LEN_W'(list_len);
		return r;
	endfunction

	function automatic void compare_field(string field, logic signed [63:0] want_v,
			logic signed [63:0] got_v);
		if (want_v !== got_v) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAP; i++) begin
				element_mirror[i] = '0;
				listed[i] = 1'b0;
				slot_of[i] = 0;
				nonzero_list[i] = 0;
			end
			list_len = 0;
			size_reg = SIZE_RESET;
			tol_reg = 0;
			awaited_results.delete();
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			// retire first, so a stray result is never matched to this edge's item
			if (out_valid && out_ready) begin
				got.status = status;
				got.element_value = element_value;
				got.entry_index = entry_index;
				got.nonzero_count = nonzero_count;
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"%0t: result expected none actual status %0d",
							" value %0d entry %0d count %0d"},
							$time, got.status, got.element_value, got.entry_index,
							got.nonzero_count);
				end else begin
					want = awaited_results.pop_front();
					compare_field("status", want.status, got.status);
					compare_field("element_value", want.element_value, got.element_value);
					compare_field("entry_index", want.entry_index, got.entry_index);
					compare_field("nonzero_count", want.nonzero_count, got.nonzero_count);
				end
			end
			if (in_valid && in_ready) begin
				want = apply_request(action, index, value, list_position);
				awaited_results = {awaited_results, want};
			end
			if (cfg_write_en) begin
				case (cfg_index)
					REG_SIZE_IN_USE: size_reg = cfg_data[SIZE_W-1:0];
					REG_ZERO_TOL: tol_reg = cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

### tb/sparse_indexed_vector_store_test.sv
`timescale 1ns / 1ps
// Testbench top for the sparse indexed vector store: clock, reset, stimulus and verdict.
// Depends on svis_pkg, the store RTL and svis_store_checker.
module sparse_indexed_vector_store_test;
	import svis_pkg::*;

	localparam int IDX_W = 10;
	localparam int VALUE_W = 48;
	localparam int LEN_W = 11;
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int PHASES = 8;
	localparam int PHASE_SIZE [PHASES] = '{1024, 1, 2047, 37, 0, 1024, 64, 1024};
	localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SIZE_IN_USE;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ACTION_W-1:0] action = ACT_RD_ELEM;
	logic [IDX_W-1:0] index = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic [IDX_W-1:0] list_position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic signed [VALUE_W-1:0] element_value;
	logic [IDX_W-1:0] entry_index;
	logic [LEN_W-1:0] nonzero_count;
	int mismatch_count;
	int outstanding;

	int burst_left = 0;
	int quiet_cycles = 0;
	int cur_size = 1024;
	int cur_tol = 0;
	bit [15:0] ready_tick = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sparse_indexed_vector_store dut (.*);

	svis_store_checker store_checker (.*);

	// receiver: free-flowing, coin-flip, sparse and long-stall stretches in turn
	always @(posedge clk) begin
		ready_tick <= ready_tick + 1'b1;
		case (ready_tick[8:7])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(1));
			2'd2: out_ready <= (ready_tick[2:0] == 3'd0);
			default: out_ready <= (ready_tick[4:0] >= 5'd20);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// hold the item until accepted; may open a gap when the burst runs out
	task automatic send(input logic [ACTION_W-1:0] act, input logic [IDX_W-1:0] idx,
			input logic signed [VALUE_W-1:0] val, input logic [IDX_W-1:0] pos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left = burst_left - 1;
		in_valid <= 1'b1;
		action <= act;
		index <= idx;
		value <= val;
		list_position <= pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic configure(input int size, input int tol);
		drain();
		cfg_write_en <= 1'b1;
		cfg_index <= REG_SIZE_IN_USE;
		cfg_data <= CFG_W'(size);
		@(posedge clk);
		cfg_index <= REG_ZERO_TOL;
		cfg_data <= CFG_W'(tol);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cur_size = size;
		cur_tol = tol;
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		logic signed [VALUE_W-1:0] v;
		longint span;
		span = cur_tol + 4;
		v = VALUE_W'({$urandom, $urandom});
		case ($urandom_range(9))
			0, 1, 2: v = VALUE_W'(longint'($urandom_range(2 * span)) - span);
			3: v = {{8{v[39]}}, v[39:0]};
			4: begin
				case ($urandom_range(3))
					0: v = VALUE_MAX;
					1: v = VALUE_MIN;
					2: v = 1;
					default: v = -1;
				endcase
			end
			5: v = '0;
			default: ;
		endcase
		return v;
	endfunction

	// mostly a small hot window, some around the in-use limit, some anywhere
	function automatic logic [IDX_W-1:0] pick_index();
		int border, lo, hi;
		border = (cur_size > 1024) ? 1024 : cur_size;
		lo = (border > 4) ? border - 4 : 0;
		hi = (border + 3 > 1023) ? 1023 : border + 3;
		case ($urandom_range(4))
			0: return IDX_W'($urandom);
			1: return IDX_W'($urandom_range(hi, lo));
			default: return IDX_W'($urandom_range(47));
		endcase
	endfunction

	task automatic send_random();
		int r;
		logic [ACTION_W-1:0] act;
		logic [IDX_W-1:0] pos;
		r = $urandom_range(99);
		if (r < 30)
			act = ACT_ADD;
		else if (r < 55)
			act = ACT_SET;
		else if (r < 70)
			act = ACT_RD_ELEM;
		else if (r < 94)
			act = ACT_RD_ENTRY;
		else if (r < 97)
			act = ACT_CLEAR;
		else
			act = ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
		pos = ($urandom_range(4) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(63));
		send(act, pick_index(), pick_value(), pos);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send(ACT_RD_ENTRY, 0, 0, 0);        // empty list
		send(ACT_SET, 1023, VALUE_MAX, 0);
		send(ACT_ADD, 1023, 1, 0);          // saturate high
		send(ACT_SET, 0, VALUE_MIN, 0);
		send(ACT_ADD, 0, -1, 0);            // saturate low
		send(ACT_SET, 5, 1, 0);
		send(ACT_RD_ENTRY, 0, 0, 1023);     // past the end of the list
		send(ACT_SET, 1023, 0, 0);          // last entry moves into the front slot
		send(ACT_RD_ENTRY, 0, 0, 0);
		send(ACT_ADD, 5, -1, 0);            // drop the front entry
		send(ACT_UNUSED_LO, 7, VALUE_MAX, 3);
		send(ACT_UNUSED_HI, 1023, VALUE_MIN, 1023);
		send(ACT_CLEAR, 0, 0, 0);
		send(ACT_RD_ELEM, 0, 0, 0);
		send(ACT_SET, 900, 12345, 0);
		configure(16, 100);
		send(ACT_SET, 3, 50, 0);            // inside tolerance: kept as is, not listed
		send(ACT_ADD, 3, 100, 0);           // leaves tolerance: listed
		send(ACT_ADD, 3, -60, 0);           // falls back in: stored as zero
		send(ACT_SET, 16, 1, 0);            // first index out of range
		send(ACT_SET, 2, 500, 0);
		configure(16, 65535);
		send(ACT_SET, 2, 600, 0);           // both inside the raised tolerance
		send(ACT_CLEAR, 0, 0, 0);           // also zeroes index 900 beyond the size
		configure(2047, 0);
		send(ACT_RD_ELEM, 900, 0, 0);
		configure(0, 0);
		send(ACT_SET, 0, 1, 0);             // nothing is in range
		send(ACT_RD_ENTRY, 0, 0, 0);

		for (int p = 0; p < PHASES; p++) begin
			configure(PHASE_SIZE[p], (p == 2) ? 65535 : (p % 3 == 0) ? 0 :
				int'($urandom_range(2000)));
			repeat ((p == 4) ? 40 : 223) begin
				send_random();
				if ($urandom_range(149) == 0)
					drain();
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
